### src/cycle_deadline_event_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef CYCLE_DEADLINE_EVENT_SCHEDULER_MACROS_SVH
`define CYCLE_DEADLINE_EVENT_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cdes_pkg.sv
// Package with the shared types and constants of the deadline event scheduler.
`default_nettype none
package cdes_pkg;

    localparam int unsigned DEFAULT_NUM_EVENTS = 13;
    localparam int unsigned CYCLE_W            = 32;
    localparam logic [CYCLE_W-1:0] NONE_DUE    = '1;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_QUERY    = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         fired_event;
        logic [CYCLE_W-1:0] next_due;
        logic [CYCLE_W-1:0] cycles_until;
        logic               last;
    } t_result;

endpackage
`default_nettype wire

### src/cdes_tgt_ram.sv
// Target cycle memory: one write port, one read port with registered read data.
`default_nettype none
module cdes_tgt_ram
    import cdes_pkg::*;
#(
    parameter int unsigned DEPTH = DEFAULT_NUM_EVENTS,
    parameter int unsigned AW    = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [CYCLE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [CYCLE_W-1:0] o_rdata
);

    logic [CYCLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/cdes_out_reg.sv
// Output register that holds one result item until the receiver takes it.
`default_nettype none
module cdes_out_reg
    import cdes_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    input  wire logic    i_stall,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_res
);

    logic r_valid;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && o_free) begin
            o_res <= i_res;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

endmodule
`default_nettype wire

### src/cycle_deadline_event_scheduler.sv
// Top level of the deadline event scheduler: control sequencer, target memory, output stage.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    i_opcode i_event_index i_delay i_now
//   output   out        o_valid / i_stall    o_kind o_fired_event o_next_due
//                                            o_cycles_until o_last
//
// A schedule or query item has its result registered on acceptance, then loaded into
// the output register in the response state; the next item can be taken once that load is
// done. A dispatch item offers its last result after a scan pass and an emit pass,
// plus any output stall: the single read port of the target memory sets the scan at one slot
// per cycle, and the emit pass then visits one slot per cycle, holding on a fired slot while the output is stalled.
// The block works on one item at a time; the input is stalled until its last
// result has been loaded into the output register. Reset is synchronous and
// active low; it clears the pending mask and sets the soonest mark to all ones.
// The target memory is not cleared, since read data is used only for pending slots.
`default_nettype none
`include "cycle_deadline_event_scheduler_macros.svh"
module cycle_deadline_event_scheduler
    import cdes_pkg::*;
#(
    parameter int unsigned NUM_EVENTS = DEFAULT_NUM_EVENTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [3:0]         i_event_index,
    input  wire logic [CYCLE_W-1:0] i_delay,
    input  wire logic [CYCLE_W-1:0] i_now,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_kind,
    output logic [3:0]              o_fired_event,
    output logic [CYCLE_W-1:0]      o_next_due,
    output logic [CYCLE_W-1:0]      o_cycles_until,
    output logic                    o_last
);

    // Address width of the slot memory and width of the scan counters, which
    // must also be able to hold NUM_EVENTS itself as the end mark.
    localparam int unsigned AW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int unsigned CW = $clog2(NUM_EVENTS + 1);
    localparam logic [CW-1:0] CNT_END = CW'(NUM_EVENTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                  r_state, n_state;
    logic [NUM_EVENTS-1:0]   r_pending, n_pending;
    logic [NUM_EVENTS-1:0]   r_fired, n_fired;
    logic [CYCLE_W-1:0]      r_soonest, n_soonest;
    logic [CYCLE_W-1:0]      r_best, n_best;
    logic [CYCLE_W-1:0]      r_now, n_now;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_emit, n_emit;
    logic                    r_chk_vld, n_chk_vld;
    logic [AW-1:0]           r_chk_slot, n_chk_slot;
    t_result                 r_resp, n_resp;

    logic                    w_accept;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [CYCLE_W-1:0]      w_target;
    logic [CYCLE_W-1:0]      w_rdata;
    logic [31:0]             w_idx_ext;
    logic [31:0]             w_emit_ext;
    logic [CYCLE_W-1:0]      w_qdiff;
    logic [CYCLE_W-1:0]      w_sdiff;
    logic                    w_push;
    logic                    w_free;
    t_result                 w_res;
    t_result                 w_out;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_idx_ext  = {28'd0, i_event_index};
    assign w_emit_ext = 32'(r_emit);
    assign w_waddr    = w_idx_ext[AW-1:0];
    assign w_target   = i_now + i_delay;
    assign w_qdiff    = i_now - r_soonest;
    // Wrap-safe due test during the scan: the slot is due when now minus its
    // target, read as a signed value, is not negative.
    assign w_sdiff    = r_now - w_rdata;

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_fired    = r_fired;
        n_soonest  = r_soonest;
        n_best     = r_best;
        n_now      = r_now;
        n_cnt      = r_cnt;
        n_emit     = r_emit;
        n_chk_vld  = r_chk_vld;
        n_chk_slot = r_chk_slot;
        n_resp     = r_resp;
        w_we       = 1'b0;
        w_push     = 1'b0;
        w_res      = r_resp;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_SCHEDULE: begin
                            // An out-of-range slot leaves all state alone but is
                            // still acknowledged.
                            if (w_idx_ext < 32'(NUM_EVENTS)) begin
                                w_we               = 1'b1;
                                n_pending[w_waddr] = 1'b1;
                                if (r_soonest > w_target || r_soonest <= i_now) begin
                                    n_soonest = w_target;
                                end
                            end
                            n_resp.kind         = KIND_ACK;
                            n_resp.fired_event  = 4'd0;
                            n_resp.next_due     = n_soonest;
                            n_resp.cycles_until = '0;
                            n_resp.last         = 1'b1;
                            n_state             = S_RESP;
                        end
                        OP_DISPATCH: begin
                            n_now     = i_now;
                            n_cnt     = '0;
                            n_chk_vld = 1'b0;
                            n_fired   = '0;
                            n_best    = NONE_DUE;
                            n_state   = S_SCAN;
                        end
                        OP_QUERY: begin
                            n_resp.kind        = KIND_QUERY;
                            n_resp.fired_event = 4'd0;
                            n_resp.next_due    = r_soonest;
                            n_resp.last        = 1'b1;
                            if (r_soonest == NONE_DUE) begin
                                n_resp.cycles_until = CYCLE_W'(1);
                            end else if (!w_qdiff[CYCLE_W-1]) begin
                                n_resp.cycles_until = '0;
                            end else begin
                                n_resp.cycles_until = r_soonest - i_now;
                            end
                            n_state = S_RESP;
                        end
                        default: begin
                            // The unused opcode is taken and dropped.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_RESP: begin
                w_push = 1'b1;
                w_res  = r_resp;
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end

            S_SCAN: begin
                // Issue one read per cycle; the data for a slot comes back in
                // the next cycle and is judged there.
                if (r_cnt != CNT_END) begin
                    n_cnt      = r_cnt + CW'(1);
                    n_chk_vld  = 1'b1;
                    n_chk_slot = r_cnt[AW-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld && r_pending[r_chk_slot]) begin
                    if (!w_sdiff[CYCLE_W-1]) begin
                        n_fired[r_chk_slot] = 1'b1;
                    end else if (w_rdata > r_now && w_rdata < r_best) begin
                        n_best = w_rdata;
                    end
                end
                if (r_cnt == CNT_END && !r_chk_vld) begin
                    n_soonest = r_best;
                    n_pending = r_pending & ~r_fired;
                    n_emit    = '0;
                    n_state   = S_EMIT;
                end
            end

            S_EMIT: begin
                w_res.fired_event  = 4'd0;
                w_res.next_due     = r_soonest;
                w_res.cycles_until = '0;
                if (r_emit == CNT_END) begin
                    w_res.kind = KIND_DONE;
                    w_res.last = 1'b1;
                    w_push     = 1'b1;
                    if (w_free) begin
                        n_state = S_IDLE;
                    end
                end else if (r_fired[r_emit[AW-1:0]]) begin
                    w_res.kind        = KIND_FIRED;
                    w_res.fired_event = w_emit_ext[3:0];
                    w_res.last        = 1'b0;
                    w_push            = 1'b1;
                    if (w_free) begin
                        n_emit = r_emit + CW'(1);
                    end
                end else begin
                    w_res.kind = KIND_FIRED;
                    w_res.last = 1'b0;
                    n_emit     = r_emit + CW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fired    <= n_fired;
        r_best     <= n_best;
        r_now      <= n_now;
        r_cnt      <= n_cnt;
        r_emit     <= n_emit;
        r_chk_slot <= n_chk_slot;
        r_resp     <= n_resp;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= '0;
            r_soonest <= NONE_DUE;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_soonest <= n_soonest;
            r_chk_vld <= n_chk_vld;
        end
    end

    // No write can meet a read of the same slot: writes happen only on
    // acceptance in idle, read data is used only during the scan, and the input is stalled
    // throughout the scan.
    cdes_tgt_ram #(
        .DEPTH (NUM_EVENTS),
        .AW    (AW)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_target),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_rdata)
    );

    cdes_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_free  (w_free),
        .o_valid (o_valid),
        .o_res   (w_out)
    );

    assign o_kind         = w_out.kind;
    assign o_fired_event  = w_out.fired_event;
    assign o_next_due     = w_out.next_due;
    assign o_cycles_until = w_out.cycles_until;
    assign o_last         = w_out.last;

    `CDES_ASSERT_NOW(a_fired_not_last, i_clk, i_rst_n,
        w_push && w_res.kind == KIND_FIRED, !w_res.last, "fired result marked last")
    `CDES_ASSERT_NOW(a_no_push_in_scan, i_clk, i_rst_n,
        r_state == S_SCAN || r_state == S_IDLE, !w_push, "result pushed outside a response state")
    `CDES_ASSERT_NEXT(a_fired_cleared, i_clk, i_rst_n,
        r_state == S_SCAN && n_state == S_EMIT, (r_pending & r_fired) == '0,
        "fired slot still pending after the scan")
    `CDES_ASSERT_NOW(a_fired_was_set, i_clk, i_rst_n,
        r_state == S_EMIT && w_push && w_res.kind == KIND_FIRED,
        r_emit != CNT_END && r_fired[r_emit[AW-1:0]], "fired result for a slot that did not fire")

endmodule
`default_nettype wire
